>>> src/pwpd_pkg.sv
// ----------------------------------------------------------------------------
// pwpd_pkg
// Shared constants, types and the bin-size divider constants for the PCM
// waveform peak decimator.
// ----------------------------------------------------------------------------
package pwpd_pkg;

  localparam int NUM_BINS  = 120;
  localparam int ADDR_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int BIN_CNT_W = $clog2(NUM_BINS + 1);

  // x / NUM_BINS == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
  localparam int DIV_SHIFT = 32 + $clog2(NUM_BINS);
  localparam logic [32:0] DIV_MAGIC =
    33'(((65'd1 << DIV_SHIFT) + 65'(NUM_BINS) - 65'd1) / 65'(NUM_BINS));

  localparam int PADDR_W = 4;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_BYTE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] pcm_byte;
    logic [6:0] bin_number;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  bits_per_sample;
    logic [7:0]  channel_count;
    logic [31:0] total_frames;
    logic [31:0] clip_frames_per_bin;
  } cfg_t;

  typedef struct packed {
    logic [6:0]         read_bin;
    logic signed [15:0] peak_min;
    logic [14:0]        peak_max;
  } res_t;

endpackage

>>> src/pwpd_cfg.sv
// ----------------------------------------------------------------------------
// pwpd_cfg
// APB register file; also derives the clip's frames per bin from total_frames.
// ----------------------------------------------------------------------------
module pwpd_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pwpd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output pwpd_pkg::cfg_t               cfg
);

  localparam logic [1:0] REG_BITS  = 2'd0;
  localparam logic [1:0] REG_CHANS = 2'd1;
  localparam logic [1:0] REG_TOTAL = 2'd2;

  logic [5:0]  bits_per_sample;
  logic [7:0]  channel_count;
  logic [31:0] total_frames;
  logic [31:0] frames_per_bin;
  logic [64:0] div_prod;
  logic [31:0] div_quot;
  logic [1:0]  reg_sel;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  assign div_prod = {33'd0, total_frames} * {32'd0, pwpd_pkg::DIV_MAGIC};
  assign div_quot = 32'(div_prod >> pwpd_pkg::DIV_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_sample <= 6'd16;
      channel_count   <= 8'd1;
      total_frames    <= '0;
      frames_per_bin  <= 32'd1;
    end else begin
      frames_per_bin <= (div_quot == '0) ? 32'd1 : div_quot;
      if (wr_en) begin
        case (reg_sel)
          REG_BITS:  bits_per_sample <= pwdata[5:0];
          REG_CHANS: channel_count   <= pwdata[7:0];
          REG_TOTAL: total_frames    <= pwdata;
          default:   ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BITS:  prdata = {26'd0, bits_per_sample};
      REG_CHANS: prdata = {24'd0, channel_count};
      REG_TOTAL: prdata = total_frames;
      default:   prdata = '0;
    endcase
  end

  assign cfg.bits_per_sample     = bits_per_sample;
  assign cfg.channel_count       = channel_count;
  assign cfg.total_frames        = total_frames;
  assign cfg.clip_frames_per_bin = frames_per_bin;

endmodule

>>> src/pwpd_front.sv
// ----------------------------------------------------------------------------
// pwpd_front
// Accepts request items, decodes the request type and queues commands.
// ----------------------------------------------------------------------------
module pwpd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     req_type,
  input  logic [7:0]     pcm_byte,
  input  logic [6:0]     bin_number,
  output logic           cmd_valid,
  output pwpd_pkg::cmd_t cmd,
  input  logic           cmd_pop
);

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  pwpd_pkg::cmd_t                 q [pwpd_pkg::CMDQ_DEPTH];
  logic [pwpd_pkg::CMDQ_AW-1:0]   wr_ptr;
  logic [pwpd_pkg::CMDQ_AW-1:0]   rd_ptr;
  logic [pwpd_pkg::CMDQ_CW-1:0]   count;
  pwpd_pkg::cmd_t                 dec;
  logic                           dec_ok;
  logic                           enq;
  logic                           deq;

  always_comb begin
    dec.pcm_byte   = pcm_byte;
    dec.bin_number = bin_number;
    dec_ok         = 1'b1;
    case (req_type)
      REQ_CLEAR: dec.op = pwpd_pkg::OP_CLEAR;
      REQ_BYTE:  dec.op = pwpd_pkg::OP_BYTE;
      REQ_READ:  dec.op = pwpd_pkg::OP_READ;
      default: begin
        dec.op = pwpd_pkg::OP_CLEAR;
        dec_ok = 1'b0;
      end
    endcase
  end

  assign full      = count == pwpd_pkg::CMDQ_CW'(pwpd_pkg::CMDQ_DEPTH);
  assign cmd_valid = count != '0;
  assign cmd       = q[rd_ptr];
  assign enq       = push && !full && dec_ok;
  assign deq       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/pwpd_back.sv
// ----------------------------------------------------------------------------
// pwpd_back
// Executes commands: frame tracking, running min/max, bin store and reads.
// ----------------------------------------------------------------------------
module pwpd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  pwpd_pkg::cfg_t              cfg,
  input  logic                        cmd_valid,
  input  pwpd_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  input  logic [pwpd_pkg::OUT_CW-1:0] out_level,
  output logic                        res_valid,
  output pwpd_pkg::res_t              res
);

  localparam int          SUM_W     = pwpd_pkg::OUT_CW + 1;
  localparam logic [5:0]  BPS_WORD  = 6'd16;
  localparam logic [5:0]  BPS_BYTE  = 6'd8;

  logic [30:0]                     mem [pwpd_pkg::NUM_BINS];
  logic [pwpd_pkg::NUM_BINS-1:0]   written;

  logic [31:0]                     frames_per_bin;
  logic [31:0]                     frames_seen;
  logic [pwpd_pkg::BIN_CNT_W-1:0]  current_bin;
  logic [31:0]                     frames_in_bin;
  logic [10:0]                     byte_in_frame;
  logic [7:0]                      held_low_byte;
  logic signed [15:0]              running_min;
  logic signed [15:0]              running_max;

  logic                            rd_pending;
  logic [6:0]                      rd_bin;
  logic                            rd_hit;
  logic [30:0]                     rd_word;

  logic [2:0]                      bps;
  logic [10:0]                     frame;
  logic [10:0]                     pos;
  logic [10:0]                     pos_inc;
  logic                            sample_done;
  logic signed [15:0]              sample;
  logic                            in_clip;
  logic                            is_byte;
  logic                            is_read;
  logic                            is_clear;
  logic                            take;
  logic signed [15:0]              new_min;
  logic signed [15:0]              new_max;
  logic [31:0]                     fib_inc;
  logic                            bin_full;
  logic                            can_read;
  logic                            rd_in_range;
  logic [pwpd_pkg::ADDR_W-1:0]     rd_addr;
  logic [pwpd_pkg::ADDR_W-1:0]     wr_addr;

  assign can_read = (SUM_W'(out_level) + SUM_W'(rd_pending)) < SUM_W'(pwpd_pkg::OUT_DEPTH);
  assign cmd_pop  = cmd_valid && ((cmd.op != pwpd_pkg::OP_READ) || can_read);
  assign is_byte  = cmd_pop && (cmd.op == pwpd_pkg::OP_BYTE);
  assign is_read  = cmd_pop && (cmd.op == pwpd_pkg::OP_READ);
  assign is_clear = cmd_pop && (cmd.op == pwpd_pkg::OP_CLEAR);

  assign bps         = cfg.bits_per_sample[5:3];
  assign frame       = 11'(bps) * 11'(cfg.channel_count);
  assign pos         = (byte_in_frame >= frame) ? 11'd0 : byte_in_frame;
  assign pos_inc     = pos + 11'd1;
  assign sample_done = pos == (11'(bps) - 11'd1);

  always_comb begin
    case (cfg.bits_per_sample)
      BPS_WORD: sample = {cmd.pcm_byte, held_low_byte};
      BPS_BYTE: sample = {~cmd.pcm_byte[7], cmd.pcm_byte[6:0], 8'h00};
      default:  sample = '0;
    endcase
  end

  assign in_clip = (frames_seen < cfg.total_frames) &&
                   (current_bin < pwpd_pkg::BIN_CNT_W'(pwpd_pkg::NUM_BINS));
  assign take    = is_byte && (frame != '0) && sample_done && in_clip;
  assign new_min = (sample < running_min) ? sample : running_min;
  assign new_max = (sample > running_max) ? sample : running_max;
  assign fib_inc = frames_in_bin + 32'd1;
  assign bin_full = fib_inc >= frames_per_bin;

  assign wr_addr     = pwpd_pkg::ADDR_W'(current_bin);
  assign rd_addr     = pwpd_pkg::ADDR_W'(cmd.bin_number);
  assign rd_in_range = 32'(cmd.bin_number) < 32'(pwpd_pkg::NUM_BINS);

  always_ff @(posedge clk) begin
    if (take) begin
      mem[wr_addr] <= {new_max[14:0], new_min};
    end
    if (is_read) begin
      rd_word <= mem[rd_addr];
      rd_bin  <= cmd.bin_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written        <= '0;
      frames_per_bin <= 32'd1;
      frames_seen    <= '0;
      current_bin    <= '0;
      frames_in_bin  <= '0;
      byte_in_frame  <= '0;
      held_low_byte  <= '0;
      running_min    <= '0;
      running_max    <= '0;
      rd_pending     <= 1'b0;
      rd_hit         <= 1'b0;
    end else begin
      rd_pending <= is_read;
      if (is_read) begin
        rd_hit <= rd_in_range && written[rd_addr];
      end
      if (is_clear) begin
        written        <= '0;
        frames_per_bin <= cfg.clip_frames_per_bin;
        frames_seen    <= '0;
        current_bin    <= '0;
        frames_in_bin  <= '0;
        byte_in_frame  <= '0;
        held_low_byte  <= '0;
        running_min    <= '0;
        running_max    <= '0;
      end else if (is_byte && (frame != '0)) begin
        if (pos == '0) begin
          held_low_byte <= cmd.pcm_byte;
        end
        byte_in_frame <= (pos_inc >= frame) ? 11'd0 : pos_inc;
        if (take) begin
          written[wr_addr] <= 1'b1;
          frames_seen      <= frames_seen + 32'd1;
          if (bin_full) begin
            current_bin   <= current_bin + 1'b1;
            frames_in_bin <= '0;
            running_min   <= '0;
            running_max   <= '0;
          end else begin
            frames_in_bin <= fib_inc;
            running_min   <= new_min;
            running_max   <= new_max;
          end
        end
      end
    end
  end

  assign res_valid    = rd_pending;
  assign res.read_bin = rd_bin;
  assign res.peak_min = rd_hit ? rd_word[15:0] : 16'sd0;
  assign res.peak_max = rd_hit ? rd_word[30:16] : 15'd0;

endmodule

>>> src/pwpd_out_queue.sv
// ----------------------------------------------------------------------------
// pwpd_out_queue
// Result queue between the back end and the result ports.
// ----------------------------------------------------------------------------
module pwpd_out_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_valid,
  input  pwpd_pkg::res_t              res,
  output logic [pwpd_pkg::OUT_CW-1:0] level,
  output logic                        empty,
  input  logic                        pop,
  output logic [6:0]                  read_bin,
  output logic signed [15:0]          peak_min,
  output logic [14:0]                 peak_max
);

  pwpd_pkg::res_t               q [pwpd_pkg::OUT_DEPTH];
  logic [pwpd_pkg::OUT_AW-1:0]  wr_ptr;
  logic [pwpd_pkg::OUT_AW-1:0]  rd_ptr;
  pwpd_pkg::res_t               head;
  logic                         deq;

  assign empty    = level == '0;
  assign deq      = pop && !empty;
  assign head     = q[rd_ptr];
  assign read_bin = head.read_bin;
  assign peak_min = head.peak_min;
  assign peak_max = head.peak_max;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({res_valid, deq})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

>>> src/pcm_waveform_peak_decimator_top.sv
// ----------------------------------------------------------------------------
// pcm_waveform_peak_decimator_top
// Min/max peak decimation of a PCM byte stream into per-bin Q15 values.
//
// Channel   Handshake              Payload
// request   push / full            req_type, pcm_byte, bin_number
// result    empty / pop            read_bin, peak_min, peak_max
// config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// One item per cycle sustained while the result queue has room for reads; a 4-deep command queue feeds the back end.
// A read result passes the command queue, the registered bin store read and the result queue
// before it shows on the result ports.
// Synchronous reset; no clearing pass, bin valid flags clear at once.
// Reads stall in the back end only while the 4-deep result queue has no room.
// ----------------------------------------------------------------------------
module pcm_waveform_peak_decimator_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   req_type,
  input  logic [7:0]                   pcm_byte,
  input  logic [6:0]                   bin_number,
  output logic                         empty,
  input  logic                         pop,
  output logic [6:0]                   read_bin,
  output logic signed [15:0]           peak_min,
  output logic [14:0]                  peak_max,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pwpd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  pwpd_pkg::cfg_t              cfg;
  pwpd_pkg::cmd_t              cmd;
  logic                        cmd_valid;
  logic                        cmd_pop;
  logic [pwpd_pkg::OUT_CW-1:0] out_level;
  logic                        res_valid;
  pwpd_pkg::res_t              res;

  pwpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pwpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .pcm_byte   (pcm_byte),
    .bin_number (bin_number),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  pwpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_level (out_level),
    .res_valid (res_valid),
    .res       (res)
  );

  pwpd_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .level     (out_level),
    .empty     (empty),
    .pop       (pop),
    .read_bin  (read_bin),
    .peak_min  (peak_min),
    .peak_max  (peak_max)
  );

endmodule

>>> src/pwpd_checker.sv
// ----------------------------------------------------------------------------
// pwpd_checker
// Port-level checks on the peak decimator, bound to the top level.
// ----------------------------------------------------------------------------
module pwpd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [6:0]                   read_bin,
  input logic signed [15:0]           peak_min,
  input logic [14:0]                  peak_max
);

  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not idle after reset");

  a_min_sign: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (peak_min[15] || (peak_min == 16'sd0)))
    else $error("peak_min above zero");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (32'(read_bin) >= 32'(pwpd_pkg::NUM_BINS)))
      |-> ((peak_min == 16'sd0) && (peak_max == 15'd0)))
    else $error("out-of-range bin returned nonzero peaks");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(read_bin) && $stable(peak_min)
                          && $stable(peak_max)))
    else $error("waiting result item changed");

endmodule

bind pcm_waveform_peak_decimator_top pwpd_checker u_checker (.*);

>>> sim/pcm_waveform_peak_decimator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_waveform_peak_decimator_top_tb
// Drives PCM byte, clear and bin read items into the decimator and checks
// every bin result against a local min/max predictor. Covers 8/16-bit and
// unmeasured sample widths, channel interleave, bin and clip frame limits,
// mid-clip register changes, random idling on both sides and a long
// receiver hold-off that backs the block up until it refuses items.
// ----------------------------------------------------------------------------
module pcm_waveform_peak_decimator_top_tb;

  localparam logic [pwpd_pkg::PADDR_W-1:0] REG_BITS  = pwpd_pkg::PADDR_W'(0);
  localparam logic [pwpd_pkg::PADDR_W-1:0] REG_CHANS = pwpd_pkg::PADDR_W'(4);
  localparam logic [pwpd_pkg::PADDR_W-1:0] REG_TOTAL = pwpd_pkg::PADDR_W'(8);
  localparam logic [1:0]                   REQ_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 500;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           push = 1'b0;
  logic                           full;
  logic [1:0]                     req_type = pwpd_pkg::OP_CLEAR;
  logic [7:0]                     pcm_byte = 8'h00;
  logic [6:0]                     bin_number = 7'd0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic [6:0]                     read_bin;
  logic signed [15:0]             peak_min;
  logic [14:0]                    peak_max;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [pwpd_pkg::PADDR_W-1:0]   paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  pcm_waveform_peak_decimator_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .pcm_byte   (pcm_byte),
    .bin_number (bin_number),
    .empty      (empty),
    .pop        (pop),
    .read_bin   (read_bin),
    .peak_min   (peak_min),
    .peak_max   (peak_max),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [31:0]        pk_word [pwpd_pkg::NUM_BINS];
  bit                 pk_valid [pwpd_pkg::NUM_BINS];
  logic [31:0]        span_frames;
  logic [31:0]        frames_done;
  int unsigned        fill_bin;
  logic [31:0]        frames_in_fill;
  int unsigned        byte_pos;
  logic [7:0]         low_byte;
  logic signed [15:0] lo_peak;
  logic signed [15:0] hi_peak;
  logic [5:0]         sample_bits;
  logic [7:0]         chans;
  logic [31:0]        clip_frames;

  pwpd_pkg::res_t expected_reads [$];
  int   errors = 0;
  int   items_sent = 0;
  bit   steady = 1'b0;
  logic hold_tgl = 1'b0;

  function automatic void start_new_clip();
    for (int i = 0; i < pwpd_pkg::NUM_BINS; i++) pk_valid[i] = 1'b0;
    span_frames = clip_frames / pwpd_pkg::NUM_BINS;
    if (span_frames == 0) span_frames = 1;
    frames_done    = 0;
    fill_bin       = 0;
    frames_in_fill = 0;
    byte_pos       = 0;
    low_byte       = 8'h00;
    lo_peak        = 16'sd0;
    hi_peak        = 16'sd0;
  endfunction

  function automatic void fold_sample(input logic signed [15:0] smp);
    if (frames_done >= clip_frames || fill_bin >= pwpd_pkg::NUM_BINS) return;
    if (smp < lo_peak) lo_peak = smp;
    if (smp > hi_peak) hi_peak = smp;
    pk_word[fill_bin]  = {hi_peak, lo_peak};
    pk_valid[fill_bin] = 1'b1;
    frames_done++;
    frames_in_fill++;
    if (frames_in_fill >= span_frames) begin
      fill_bin++;
      frames_in_fill = 0;
      lo_peak = 16'sd0;
      hi_peak = 16'sd0;
    end
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    int unsigned        smp_bytes;
    int unsigned        frame_len;
    int unsigned        pos;
    logic signed [15:0] smp;
    smp_bytes = sample_bits / 8;
    frame_len = smp_bytes * chans;
    if (frame_len == 0) return;
    pos = byte_pos;
    if (pos >= frame_len) pos = 0;
    if (pos == 0) low_byte = b;
    if (pos == smp_bytes - 1) begin
      smp = 16'sd0;
      if (sample_bits == 6'd16) smp = {b, low_byte};
      else if (sample_bits == 6'd8) smp = {~b[7], b[6:0], 8'h00};
      fold_sample(smp);
    end
    pos++;
    byte_pos = (pos >= frame_len) ? 0 : pos;
  endfunction

  function automatic void predict_item(input logic [1:0] req, input logic [7:0] b,
                                       input logic [6:0] bn);
    pwpd_pkg::res_t r;
    logic [31:0]    word;
    if (req == pwpd_pkg::OP_CLEAR) begin
      start_new_clip();
    end else if (req == pwpd_pkg::OP_BYTE) begin
      absorb_byte(b);
    end else if (req == pwpd_pkg::OP_READ) begin
      word = '0;
      if (bn < pwpd_pkg::NUM_BINS) begin
        if (pk_valid[bn]) word = pk_word[bn];
      end
      r.read_bin = bn;
      r.peak_min = word[15:0];
      r.peak_max = word[30:16];
      expected_reads.push_back(r);
    end
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic [1:0] req, input logic [7:0] b, input logic [6:0] bn);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    req_type   <= req;
    pcm_byte   <= b;
    bin_number <= bn;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_item(req, b, bn);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(pwpd_pkg::OP_BYTE, b, 7'($urandom()));
  endtask

  task automatic send_read(input logic [6:0] bn);
    send_item(pwpd_pkg::OP_READ, 8'($urandom()), bn);
  endtask

  task automatic send_clear();
    send_item(pwpd_pkg::OP_CLEAR, 8'($urandom()), 7'($urandom()));
  endtask

  // block idle: all reads back and the command queue flushed
  task automatic settle();
    push <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pwpd_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      REG_BITS:  sample_bits = data[5:0];
      REG_CHANS: chans       = data[7:0];
      REG_TOTAL: clip_frames = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_format(input int bits, input int ch, input logic [31:0] total);
    settle();
    write_reg(REG_BITS, 32'(bits));
    write_reg(REG_CHANS, 32'(ch));
    write_reg(REG_TOTAL, total);
  endtask

  // result side: check, random stalls, calm stretches, long hold-off on request
  always @(posedge clk) begin
    int             stall_left;
    int             hold_left;
    int             calm_left;
    bit             calm;
    logic           hold_seen;
    pwpd_pkg::res_t want;
    if (rst) begin
      pop        <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      calm_left  = 0;
      calm       = 1'b0;
      hold_seen  = hold_tgl;
    end else begin
      if (pop && !empty) begin
        if (expected_reads.size() == 0) begin
          $error("result with nothing expected: read_bin %0d", read_bin);
          errors++;
        end else begin
          want = expected_reads.pop_front();
          if (read_bin !== want.read_bin) begin
            $error("read_bin: expected %0d, got %0d", want.read_bin, read_bin);
            errors++;
          end
          if (peak_min !== want.peak_min) begin
            $error("peak_min: expected %0d, got %0d", want.peak_min, peak_min);
            errors++;
          end
          if (peak_max !== want.peak_max) begin
            $error("peak_max: expected %0d, got %0d", want.peak_max, peak_max);
            errors++;
          end
        end
      end
      if (calm_left == 0) begin
        calm_left = 200;
        calm = ($urandom_range(0, 3) == 0);
      end else begin
        calm_left--;
      end
      if (hold_tgl != hold_seen) begin
        hold_seen = hold_tgl;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 25) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    int quiet;
    if (rst) begin
      quiet = 0;
    end else begin
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("pcm_waveform_peak_decimator_top_tb: errors");
        $finish;
      end
    end
  end

  task automatic test_directed();
    set_format(16, 1, 32'd240);
    send_clear();
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_read(7'd0);
    send_byte(8'h01);
    send_byte(8'h00);
    send_read(7'd1);
    send_read(7'd119);
    send_read(7'd127);
    send_item(REQ_UNUSED, 8'hFF, 7'h7F);
    send_read(7'd2);
    settle();
    write_reg(REG_BITS, 32'd8);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_read(7'd1);
    send_read(7'd2);
    send_read(7'd3);
    send_clear();
    send_read(7'd0);
  endtask

  task automatic test_frame_limits();
    // 8-bit mono, one frame per bin, ten frames past the last bin
    set_format(8, 1, 32'd130);
    send_clear();
    for (int i = 0; i < 130; i++) begin
      send_byte(8'($urandom()));
      if ($urandom_range(0, 9) == 0) send_read(7'($urandom_range(0, 127)));
    end
    send_read(7'd118);
    send_read(7'd119);
    send_read(7'd0);
    // frames past the clip length
    set_format(16, 1, 32'd3);
    send_clear();
    for (int i = 0; i < 10; i++) send_byte(8'($urandom()));
    for (int i = 0; i < 5; i++) send_read(7'(i));
    // empty clip
    set_format(16, 1, 32'd0);
    send_clear();
    for (int i = 0; i < 6; i++) send_byte(8'($urandom()));
    send_read(7'd0);
    // huge clip, everything in bin zero
    set_format(16, 1, 32'hFFFF_FFFF);
    send_clear();
    for (int i = 0; i < 20; i++) send_byte(8'($urandom()));
    send_read(7'd0);
    send_read(7'd1);
  endtask

  task automatic test_odd_formats();
    set_format(24, 1, 32'd10);
    send_clear();
    for (int i = 0; i < 12; i++) send_byte(8'($urandom()));
    for (int i = 0; i < 4; i++) send_read(7'(i));
    set_format(32, 2, 32'd10);
    send_clear();
    for (int i = 0; i < 16; i++) send_byte(8'($urandom()));
    send_read(7'd0);
    send_read(7'd1);
    set_format(7, 1, 32'd10);
    send_clear();
    for (int i = 0; i < 6; i++) send_byte(8'($urandom()));
    send_read(7'd0);
    set_format(16, 0, 32'd10);
    send_clear();
    for (int i = 0; i < 6; i++) send_byte(8'($urandom()));
    send_read(7'd0);
    set_format(63, 1, 32'd10);
    send_clear();
    for (int i = 0; i < 15; i++) send_byte(8'($urandom()));
    send_read(7'd0);
    send_read(7'd1);
    // three channels; only the first is measured
    set_format(16, 3, 32'd20);
    send_clear();
    for (int i = 0; i < 19; i++) send_byte(8'($urandom()));
    for (int i = 0; i < 4; i++) send_read(7'(i));
    // narrower frame mid-clip: position wraps
    settle();
    write_reg(REG_CHANS, 32'd1);
    for (int i = 0; i < 9; i++) send_byte(8'($urandom()));
    for (int i = 0; i < 9; i++) send_read(7'(i));
    set_format(8, 255, 32'd4);
    send_clear();
    for (int i = 0; i < 260; i++) send_byte(8'($urandom()));
    send_read(7'd0);
    send_read(7'd1);
    send_read(7'd2);
  endtask

  task automatic test_random_streams();
    int first;
    int len;
    int r;
    int hi;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 5) write_reg(REG_BITS, 32'({$urandom(), 6'd16}));
      else if (r < 7) write_reg(REG_BITS, 32'({$urandom(), 6'd8}));
      else if (r < 8) write_reg(REG_BITS, $urandom());
      else if (r < 9) write_reg(REG_BITS, ($urandom_range(0, 1) == 0) ? 32'd24 : 32'd32);
      r = $urandom_range(0, 9);
      if (r < 7) write_reg(REG_CHANS, 32'({$urandom(), 8'($urandom_range(1, 3))}));
      else if (r < 8) write_reg(REG_CHANS, $urandom());
      r = $urandom_range(0, 7);
      if (r < 3) write_reg(REG_TOTAL, $urandom_range(0, 60));
      else if (r < 6) write_reg(REG_TOTAL, $urandom_range(120, 480));
      else if (r < 7) write_reg(REG_TOTAL, 32'hFFFF_FFFF);
      else write_reg(REG_TOTAL, $urandom());
      if ($urandom_range(0, 4) != 0) send_clear();
      len = $urandom_range(60, 200);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_byte(8'($urandom()));
        end else if (r < 94) begin
          hi = (fill_bin > pwpd_pkg::NUM_BINS - 1) ? pwpd_pkg::NUM_BINS - 1 : fill_bin;
          if ($urandom_range(0, 9) < 7) send_read(7'($urandom_range(0, hi)));
          else send_read(7'($urandom_range(0, 127)));
        end else if (r < 97) begin
          send_item(REQ_UNUSED, 8'($urandom()), 7'($urandom()));
        end else begin
          send_clear();
        end
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    settle();
    hold_tgl <= ~hold_tgl;
    steady = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 3) send_byte(8'($urandom()));
      else send_read(7'($urandom_range(0, 127)));
    end
    steady = 1'b0;
  endtask

  initial begin
    sample_bits = 6'd16;
    chans       = 8'd1;
    clip_frames = 32'd0;
    start_new_clip();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_frame_limits();
    test_odd_formats();
    test_backpressure();
    test_random_streams();
    test_backpressure();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_reads.size() == 0) begin
      $display("pcm_waveform_peak_decimator_top_tb: clean");
    end else begin
      if (expected_reads.size() != 0)
        $error("%0d results never arrived", expected_reads.size());
      $display("pcm_waveform_peak_decimator_top_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/pwpd_pkg.sv
src/pwpd_cfg.sv
src/pwpd_front.sv
src/pwpd_back.sv
src/pwpd_out_queue.sv
src/pcm_waveform_peak_decimator_top.sv
src/pwpd_checker.sv
sim/pcm_waveform_peak_decimator_top_tb.sv
